### rtl/core/pkf_pkg.sv
// ----------------------------------------------------------------------------
// pkf_pkg: shared types and constants of the pitch Kalman filter
// Holds the CORDIC arctangent table, register indexes and a saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none
package pkf_pkg;

  localparam int AtanEntries = 24;

  typedef enum logic [1:0] {
    REG_STEP_TIME   = 2'd0,
    REG_ANGLE_NOISE = 2'd1,
    REG_BIAS_NOISE  = 2'd2,
    REG_MEAS_NOISE  = 2'd3
  } reg_idx_t;

  // Arctangent of 2^-i in degrees, Q12.20.
  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd47185920;
      5'd1:  v = 32'sd27855475;
      5'd2:  v = 32'sd14718068;
      5'd3:  v = 32'sd7471121;
      5'd4:  v = 32'sd3750058;
      5'd5:  v = 32'sd1876857;
      5'd6:  v = 32'sd938658;
      5'd7:  v = 32'sd469357;
      5'd8:  v = 32'sd234682;
      5'd9:  v = 32'sd117342;
      5'd10: v = 32'sd58671;
      5'd11: v = 32'sd29335;
      5'd12: v = 32'sd14668;
      5'd13: v = 32'sd7334;
      5'd14: v = 32'sd3667;
      5'd15: v = 32'sd1833;
      5'd16: v = 32'sd917;
      5'd17: v = 32'sd458;
      5'd18: v = 32'sd229;
      5'd19: v = 32'sd115;
      5'd20: v = 32'sd57;
      5'd21: v = 32'sd29;
      5'd22: v = 32'sd14;
      5'd23: v = 32'sd7;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/pkf_div.sv
// ----------------------------------------------------------------------------
// pkf_div: iterative signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module pkf_div (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire signed [63:0] num,
  input  wire signed [63:0] den,
  output logic              done,
  output logic signed [63:0] quo
);
  logic [63:0] rem_r, rem_nxt, q_r, q_nxt, d_r;
  logic        neg_r, busy_r;
  logic [6:0]  cnt_r;
  logic [64:0] trial;
  logic [63:0] an, ad;

  assign an = num[63] ? 64'(-num) : num;
  assign ad = den[63] ? 64'(-den) : den;
  assign trial = {rem_r, q_r[63]} - {1'b0, d_r};

  always_comb begin
    rem_nxt = {rem_r[62:0], q_r[63]};
    q_nxt   = {q_r[62:0], 1'b0};
    if (!trial[64]) begin
      rem_nxt = trial[63:0];
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd64;
      rem_r  <= '0;
      q_r    <= an;
      d_r    <= ad;
      neg_r  <= num[63] ^ den[63];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_r <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  assign quo = neg_r ? 64'(-q_r) : q_r;
endmodule
`default_nettype wire

### rtl/core/pkf_sqrt.sv
// ----------------------------------------------------------------------------
// pkf_sqrt: iterative integer square root
// Digit-by-digit method, one result bit per cycle over a 48 bit operand.
// ----------------------------------------------------------------------------
`default_nettype none
module pkf_sqrt (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  input  wire [47:0] val,
  output logic       done,
  output logic [47:0] root
);
  logic [47:0] v_r, r_r, bit_r;
  logic        busy_r;
  logic [48:0] sum;

  assign sum = {1'b0, r_r} + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      v_r    <= val;
      r_r    <= '0;
      bit_r  <= 48'h4000_0000_0000;
    end else if (busy_r) begin
      if ({1'b0, v_r} >= sum) begin
        v_r <= 48'({1'b0, v_r} - sum);
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
      if (bit_r[1:0] != 2'b00 || bit_r == 48'd1) begin
        busy_r <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  assign root = r_r;
endmodule
`default_nettype wire

### rtl/core/pitch_kalman_filter_top.sv
// ----------------------------------------------------------------------------
// pitch_kalman_filter_top: gyro plus accelerometer pitch Kalman filter
// Sequenced datapath around one shared multiplier, a CORDIC step, a
// square-root unit and a divider.
// ----------------------------------------------------------------------------
// Usage: a request on the in_ channel carries one accelerometer sample and
// the pitch gyro rate. The block takes it when in_valid is high and in_stall
// is low, then holds in_stall high while it works. It forms acc_y^2+acc_z^2
// on the shared multiplier, takes the square root, runs CORDIC_STEPS CORDIC
// iterations (at most pkf_pkg::AtanEntries, one per cycle, none for an
// all-zero vector), does the predict step in seven sequencer steps and
// divides twice for the gains (one quotient bit per cycle, skipped when the
// innovation variance is not positive). The update then runs on the same
// multiplier. The next request is taken only once the result is written to
// the output register; the two divisions take most of the time per item.
// The result sits in an output register with out_valid high until the
// receiver drops out_stall; the next request is taken while that result still
// waits, but the block will not finish it until the register is free. Reset
// clears the state estimates and covariance to zero and loads the register
// reset values. Configuration writes via cfg_ are accepted whenever cfg_valid
// is high and belong between items.
// ----------------------------------------------------------------------------
`default_nettype none
module pitch_kalman_filter_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [15:0] in_acc_x,
  input  wire signed [15:0] in_acc_y,
  input  wire signed [15:0] in_acc_z,
  input  wire signed [23:0] in_gyro_rate,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [23:0] out_pitch_angle,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [1:0]         cfg_index,
  input  wire [23:0]        cfg_data
);
  localparam int Steps = (CORDIC_STEPS > pkf_pkg::AtanEntries) ? pkf_pkg::AtanEntries
                                                                : CORDIC_STEPS;

  typedef enum logic [3:0] {
    S_IDLE, S_MAG, S_SQRT, S_CORDIC, S_PRED, S_DIV0, S_DIV1, S_UPD, S_OUT
  } state_t;

  state_t state_r;
  logic [4:0] step_r;
  logic [15:0] dt_r;
  logic [23:0] qa_r, qb_r, r_r;
  logic signed [31:0] ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0] ax_r, ay_r, az_r;
  logic signed [31:0] gyro_r;
  logic signed [63:0] cx_r, cy_r, cz_r, meas_r, k0_r, k1_r, s_r, tmp_r;

  // Shared multiplier with rounding shift. The first operand is dt, a gain or an
  // accelerometer term, the second a rate, innovation, noise, accelerometer or covariance term.
  logic signed [32:0] ma;
  logic signed [33:0] mb;
  logic signed [66:0] prod;
  logic [4:0] msh;
  logic signed [63:0] mres;
  always_comb begin
    prod = ma * mb;
    mres = 64'((prod + (67'sd1 <<< (msh - 5'd1))) >>> msh);
  end

  logic sq_start, sq_done, dv_start, dv_done;
  logic [47:0] sq_root;
  logic signed [63:0] dv_num, dv_quo;

  pkf_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start),
    .val(48'(cx_r) << 16), .done(sq_done), .root(sq_root));
  pkf_div u_div (.clk(clk), .rst_n(rst_n), .start(dv_start),
    .num(dv_num), .den(s_r), .done(dv_done), .quo(dv_quo));

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign sq_start  = (state_r == S_MAG && step_r == 5'd2);
  // The first division starts from the predict step, the second one as the
  // first finishes.
  assign dv_num    = (state_r == S_PRED ? 64'(p00_r) : 64'(p10_r)) <<< 24;
  assign dv_start  = (state_r == S_PRED && step_r == 5'd6 && s_r > 0) ||
                     (state_r == S_DIV0 && dv_done);

  // Operand selection per sequencer step.
  always_comb begin
    ma = 33'(dt_r); mb = '0; msh = 5'd16;
    case (state_r)
      S_MAG: begin
        case (step_r)
          5'd0: begin ma = 33'(ay_r); mb = 34'(ay_r); end
          5'd1: begin ma = 33'(az_r); mb = 34'(az_r); end
          default: ;
        endcase
      end
      S_PRED: begin
        case (step_r)
          5'd0: mb = 34'((64'(gyro_r) <<< 8) - 64'(bias_r));
          5'd1: mb = 34'(p11_r);
          5'd2: mb = 34'(tmp_r);
          5'd3: mb = 34'(qb_r);
          default: mb = '0;
        endcase
      end
      S_UPD: begin
        msh = 5'd24;
        case (step_r)
          5'd0: begin ma = 33'(k0_r); mb = 34'(meas_r - 64'(ang_r)); end
          5'd1: begin ma = 33'(k1_r); mb = 34'(meas_r - 64'(ang_r)); end
          5'd2: begin ma = 33'(k1_r); mb = 34'(p00_r); end
          5'd3: begin ma = 33'(k1_r); mb = 34'(p01_r); end
          5'd4: begin ma = 33'(k0_r); mb = 34'(p00_r); end
          5'd5: begin ma = 33'(k0_r); mb = 34'(p01_r); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      default: ;
    endcase
  end

  logic signed [63:0] cxs, cys, orn;
  assign cxs = cx_r >>> step_r;
  assign cys = cy_r >>> step_r;
  assign orn = (64'(ang_r) + 64'sd128) >>> 8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      dt_r <= 16'd655; qa_r <= 24'd16777; qb_r <= 24'd50332; r_r <= 24'd503316;
      ang_r <= '0; bias_r <= '0;
      p00_r <= '0; p01_r <= '0; p10_r <= '0; p11_r <= '0;
      step_r <= '0;
    end else begin
      if (out_valid && !out_stall && state_r != S_OUT) out_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          pkf_pkg::REG_STEP_TIME:   dt_r <= cfg_data[15:0];
          pkf_pkg::REG_ANGLE_NOISE: qa_r <= cfg_data;
          pkf_pkg::REG_BIAS_NOISE:  qb_r <= cfg_data;
          pkf_pkg::REG_MEAS_NOISE:  r_r  <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ax_r <= 32'(in_acc_x); ay_r <= 32'(in_acc_y); az_r <= 32'(in_acc_z);
            gyro_r <= 32'(in_gyro_rate);
            state_r <= S_MAG;
            step_r <= '0;
          end
        end
        S_MAG: begin
          // Square y, then add the square of z, then start the root on the sum.
          case (step_r)
            5'd0: cx_r <= 64'(prod);
            5'd1: cx_r <= cx_r + 64'(prod);
            default: ;
          endcase
          if (step_r == 5'd2) begin
            step_r <= '0;
            state_r <= S_SQRT;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            cx_r <= 64'(sq_root);
            cy_r <= 64'(ax_r) <<< 8;
            cz_r <= '0;
            step_r <= '0;
            state_r <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cx_r == 0 && cy_r == 0) begin
            meas_r <= '0;
            step_r <= '0;
            state_r <= S_PRED;
          end else begin
            if (!cy_r[63]) begin
              cx_r <= cx_r + cys; cy_r <= cy_r - cxs;
              cz_r <= cz_r + 64'(pkf_pkg::atan_deg(step_r));
            end else begin
              cx_r <= cx_r - cys; cy_r <= cy_r + cxs;
              cz_r <= cz_r - 64'(pkf_pkg::atan_deg(step_r));
            end
            if (32'(step_r) == Steps - 1) begin
              meas_r <= -(cz_r + (cy_r[63] ? -64'(pkf_pkg::atan_deg(step_r))
                                           : 64'(pkf_pkg::atan_deg(step_r))));
              step_r <= '0;
              state_r <= S_PRED;
            end else begin
              step_r <= step_r + 5'd1;
            end
          end
        end
        S_PRED: begin
          case (step_r)
            5'd0: ang_r <= pkf_pkg::sat32(64'(ang_r) + mres);
            5'd1: begin
              tmp_r <= mres - 64'(p01_r) - 64'(p10_r) + signed'(64'(qa_r));
              p01_r <= pkf_pkg::sat32(64'(p01_r) - mres);
              p10_r <= pkf_pkg::sat32(64'(p10_r) - mres);
            end
            5'd2: p00_r <= pkf_pkg::sat32(64'(p00_r) + mres);
            5'd3: p11_r <= pkf_pkg::sat32(64'(p11_r) + mres);
            5'd4: s_r <= 64'(p00_r) + signed'(64'(r_r));
            5'd5: begin k0_r <= '0; k1_r <= '0; end
            default: ;
          endcase
          if (step_r == 5'd6) begin
            step_r <= '0;
            state_r <= (s_r > 0) ? S_DIV0 : S_UPD;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        S_DIV0: if (dv_done) begin
          k0_r <= 64'(pkf_pkg::sat32(dv_quo));
          state_r <= S_DIV1;
        end
        S_DIV1: if (dv_done) begin
          k1_r <= 64'(pkf_pkg::sat32(dv_quo));
          step_r <= '0;
          state_r <= S_UPD;
        end
        S_UPD: begin
          // The covariance terms that use the gain on row one go first, while
          // P00 and P01 still hold their predicted values.
          step_r <= step_r + 5'd1;
          case (step_r)
            5'd0: tmp_r <= 64'(ang_r) + mres;
            5'd1: bias_r <= pkf_pkg::sat32(64'(bias_r) + mres);
            5'd2: p10_r <= pkf_pkg::sat32(64'(p10_r) - mres);
            5'd3: p11_r <= pkf_pkg::sat32(64'(p11_r) - mres);
            5'd4: p00_r <= pkf_pkg::sat32(64'(p00_r) - mres);
            5'd5: begin
              p01_r <= pkf_pkg::sat32(64'(p01_r) - mres);
              ang_r <= pkf_pkg::sat32(tmp_r);
              state_r <= S_OUT;
            end
            default: ;
          endcase
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (orn > 64'sd8388607) out_pitch_angle <= 24'sh7fffff;
            else if (orn < -64'sd8388608) out_pitch_angle <= 24'sh800000;
            else out_pitch_angle <= orn[23:0];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
